FILE: rtl/tct_pkg.sv
// Shared types, constants and functions of the TCP connection tracker.
// Used by the tracker cell and the top level; depends on nothing else.

package tct_pkg;

   localparam int TABLE_SLOTS = 64;
   localparam int SLOT_FIELD_W = 6;

   localparam int FL_FIN_BIT = 0;
   localparam int FL_SYN_BIT = 1;
   localparam int FL_RST_BIT = 2;
   localparam int FL_ACK_BIT = 4;

   typedef enum logic [2:0] {
      CS_INIT   = 3'd0,
      CS_SYN    = 3'd1,
      CS_SYNACK = 3'd2,
      CS_ESTB   = 3'd3,
      CS_FINACK = 3'd4
   } conn_state_type;

   typedef enum logic [1:0] {
      EV_NOCHG = 2'd0,
      EV_ESTB  = 2'd1,
      EV_REL   = 2'd2,
      EV_FULL  = 2'd3
   } event_type;

   typedef struct packed {
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  tcp_flags;
   } pkt_type;

   typedef struct packed {
      event_type                 event_res;
      logic [SLOT_FIELD_W-1:0]   slot;
      logic                      is_new;
      conn_state_type            conn_state;
   } rsp_type;

   typedef struct packed {
      logic    active;
      logic    done;
      rsp_type rsp;
   } link_type;

   typedef struct packed {
      conn_state_type next_state;
      event_type      ev;
   } step_type;

   function automatic logic entry_match(logic [31:0] ip_a, logic [31:0] ip_b,
                                        logic [15:0] port_a, logic [15:0] port_b,
                                        pkt_type pkt);
      logic m;
      m = (ip_a == pkt.src_ip || ip_b == pkt.src_ip) &&
          (ip_a == pkt.dst_ip || ip_b == pkt.dst_ip) &&
          (port_a == pkt.src_port || port_b == pkt.src_port) &&
          (port_a == pkt.dst_port || port_b == pkt.dst_port);
      return m;
   endfunction

   function automatic step_type advance(conn_state_type cur, logic [7:0] flags);
      step_type s;
      logic     syn;
      logic     ack;
      logic     fin;
      logic     rst;
      syn = flags[FL_SYN_BIT];
      ack = flags[FL_ACK_BIT];
      fin = flags[FL_FIN_BIT];
      rst = flags[FL_RST_BIT];
      s.next_state = cur;
      s.ev = EV_NOCHG;
      if (rst) begin
         s.next_state = CS_INIT;
         s.ev = (cur == CS_ESTB) ? EV_REL : EV_NOCHG;
      end else begin
         case (cur)
            CS_INIT: begin
               if (syn) s.next_state = CS_SYN;
            end
            CS_SYN: begin
               if (syn && ack) s.next_state = CS_SYNACK;
            end
            CS_SYNACK: begin
               if (ack) begin
                  s.next_state = CS_ESTB;
                  s.ev = EV_ESTB;
               end
            end
            CS_ESTB: begin
               if (fin && ack) s.next_state = CS_FINACK;
            end
            CS_FINACK: begin
               if (ack) begin
                  s.next_state = CS_INIT;
                  s.ev = EV_REL;
               end
            end
            default: begin
               s.next_state = cur;
            end
         endcase
      end
      return s;
   endfunction

endpackage

FILE: rtl/tct_cell.sv
// One table slot of the connection tracker: stored connection, match and state update.
// Depends on tct_pkg; the top level chains TABLE_SLOTS of these cells.

module tct_cell
   import tct_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  pkt_type                 pkt,
   input  logic [SLOT_FIELD_W-1:0] cell_slot,
   input  link_type                prev_link,
   output link_type                next_link
);

   logic           valid_ff;
   logic           valid_in;
   logic [31:0]    ip_a_ff;
   logic [31:0]    ip_b_ff;
   logic [15:0]    port_a_ff;
   logic [15:0]    port_b_ff;
   conn_state_type cstate_ff;
   conn_state_type cstate_in;
   link_type       link_ff;
   link_type       link_in;

   logic     hit;
   logic     take;
   logic     create;
   step_type step;

   always_comb begin
      hit = valid_ff && entry_match(ip_a_ff, ip_b_ff, port_a_ff, port_b_ff, pkt);
      create = prev_link.active && !valid_ff;
      take = prev_link.active && (hit || !valid_ff);
      step = advance(hit ? cstate_ff : CS_INIT, pkt.tcp_flags);
      valid_in = valid_ff | take;
      cstate_in = take ? step.next_state : cstate_ff;

      link_in = '0;
      if (prev_link.active) begin
         if (take) begin
            link_in.done = 1'b1;
            link_in.rsp.event_res = step.ev;
            link_in.rsp.slot = cell_slot;
            link_in.rsp.is_new = !valid_ff;
            link_in.rsp.conn_state = step.next_state;
         end else begin
            link_in.active = 1'b1;
         end
      end else if (prev_link.done) begin
         link_in = prev_link;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         link_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         link_ff <= link_in;
      end
   end

   always_ff @(posedge clock) begin
      if (create) begin
         ip_a_ff <= pkt.src_ip;
         ip_b_ff <= pkt.dst_ip;
         port_a_ff <= pkt.src_port;
         port_b_ff <= pkt.dst_port;
      end
      cstate_ff <= cstate_in;
   end

   assign next_link = link_ff;

endmodule

FILE: rtl/tcp_connection_tracker.sv
// Top level of the TCP connection tracker: request intake, cell chain and result buffer.
// Depends on tct_pkg and tct_cell.

// Each request is one TCP packet. The connection table lives in a chain of TABLE_SLOTS cells,
// one slot per cell, filled in order from slot 0. The search token enters the first cell in the
// cycle after the request is accepted and moves one cell per cycle; the first valid cell whose
// stored addresses and ports match, or else the first empty cell, updates its state and the
// result rides the rest of the chain to the end. The input stalls from acceptance until the
// result leaves the end of the chain, so a new request is not taken before the last one is
// through the chain, and the wait grows with its length. Results wait in a two-entry buffer,
// so one result waiting on a stalled result channel does not hold up the next request; with
// both entries full the input stalls. When every slot is in use and nothing matches, the
// result is a table full error. Reset clears the table; slots are never freed.

module tcp_connection_tracker
   import tct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_src_ip,
   input  logic [31:0] req_dst_ip,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic [7:0]  req_tcp_flags,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_res,
   output logic [5:0]  rsp_slot,
   output logic        rsp_is_new,
   output logic [2:0]  rsp_conn_state
);

   typedef enum logic [1:0] {
      CTL_IDLE = 2'b01,
      CTL_BUSY = 2'b10
   } ctl_state_type;

   ctl_state_type ctl_ff;
   ctl_state_type ctl_in;
   pkt_type       pkt_ff;
   logic          start_ff;
   rsp_type       out_ff;
   rsp_type       out_in;
   logic          out_valid_ff;
   logic          out_valid_in;
   rsp_type       hold_ff;
   rsp_type       hold_in;
   logic          hold_valid_ff;
   logic          hold_valid_in;

   link_type links [TABLE_SLOTS+1];
   logic     accept;
   logic     end_fire;
   rsp_type  end_rsp;
   logic     out_free;

   assign req_stall = !((ctl_ff == CTL_IDLE) && !hold_valid_ff);
   assign accept = req_valid && !req_stall;

   always_comb begin
      links[0] = '0;
      links[0].active = start_ff;
   end

   genvar gi;
   generate
      for (gi = 0; gi < TABLE_SLOTS; gi++) begin : g_cell
         tct_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .pkt       (pkt_ff),
            .cell_slot (SLOT_FIELD_W'(gi)),
            .prev_link (links[gi]),
            .next_link (links[gi+1])
         );
      end
   endgenerate

   always_comb begin
      end_fire = links[TABLE_SLOTS].active || links[TABLE_SLOTS].done;
      if (links[TABLE_SLOTS].done) begin
         end_rsp = links[TABLE_SLOTS].rsp;
      end else begin
         end_rsp = '0;
         end_rsp.event_res = EV_FULL;
         end_rsp.conn_state = CS_INIT;
      end

      ctl_in = ctl_ff;
      case (ctl_ff)
         CTL_IDLE: begin
            if (accept) ctl_in = CTL_BUSY;
         end
         CTL_BUSY: begin
            if (end_fire) ctl_in = CTL_IDLE;
         end
         default: begin
            ctl_in = CTL_IDLE;
         end
      endcase

      out_free = !out_valid_ff || !rsp_stall;
      out_in = out_ff;
      out_valid_in = out_valid_ff;
      hold_in = hold_ff;
      hold_valid_in = hold_valid_ff;
      if (out_free) begin
         if (hold_valid_ff) begin
            out_in = hold_ff;
            out_valid_in = 1'b1;
            hold_in = end_rsp;
            hold_valid_in = end_fire;
         end else if (end_fire) begin
            out_in = end_rsp;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (end_fire) begin
         hold_in = end_rsp;
         hold_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= CTL_IDLE;
         start_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         ctl_ff <= ctl_in;
         start_ff <= accept;
         out_valid_ff <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pkt_ff.src_ip <= req_src_ip;
         pkt_ff.dst_ip <= req_dst_ip;
         pkt_ff.src_port <= req_src_port;
         pkt_ff.dst_port <= req_dst_port;
         pkt_ff.tcp_flags <= req_tcp_flags;
      end
      out_ff <= out_in;
      hold_ff <= hold_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_event_res = out_ff.event_res;
   assign rsp_slot = out_ff.slot;
   assign rsp_is_new = out_ff.is_new;
   assign rsp_conn_state = out_ff.conn_state;

endmodule
